// ===== design/dmpr_pkg.sv =====
// Shared types, widths and constants of the dual motor PI speed regulator.
// Depends on nothing; every module of the block imports it.
package dmpr_pkg;

    localparam int POS_W     = 32;
    localparam int SPEED_W   = 32;
    localparam int DRIVE_W   = 25;
    localparam int SDRIVE_W  = DRIVE_W + 1;
    localparam int CFG_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int PWM_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int QUOT_W    = 26;
    localparam int PWM_SUM_W = 31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN_RIGHT = 3'd5;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]  RST_TARGET_SPEED     = 24'd13107;
    localparam logic [CFG_W-1:0]  RST_OUTPUT_LIMIT     = 24'd6553600;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN_LEFT   = 16'd1408;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN_LEFT  = 16'd256;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN_RIGHT  = 16'd1280;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN_RIGHT = 16'd26;

    // Motion codes.
    localparam logic [2:0] MOTION_STOP     = 3'd0;
    localparam logic [2:0] MOTION_FORWARD  = 3'd1;
    localparam logic [2:0] MOTION_BACKWARD = 3'd2;
    localparam logic [2:0] MOTION_CW       = 3'd3;
    localparam logic [2:0] MOTION_CCW      = 3'd4;

    // Motor selection codes.
    localparam logic [1:0] MOTOR_LEFT  = 2'd1;
    localparam logic [1:0] MOTOR_RIGHT = 2'd2;

    // Division by 100: floor(2^32 / 100) as reciprocal, then one correction.
    localparam logic [QUOT_W-1:0] DIV_RECIP = 26'd42949672;
    localparam logic [6:0]        SPEED_DIV = 7'd100;

    // PWM center in Q16.16.
    localparam logic [PWM_SUM_W-1:0] PWM_CENTER_Q16 = 31'd491520000;

    // Control carried along the pipeline for one transaction.
    typedef struct packed {
        logic       valid;
        logic       regulate;
        logic       divide;
        logic [2:0] motion;
        logic [1:0] motor;
    } stage_t;

    // Control from the top level to the speed estimators.
    typedef struct packed {
        logic advance;
        logic hold;
        logic update;
    } spd_ctl_t;

endpackage

// ===== design/dmpr_speed_est.sv =====
// Speed estimator of one wheel: held position, difference and division by 100.
// Depends on dmpr_pkg; instantiated twice by the top level.
module dmpr_speed_est
    import dmpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  spd_ctl_t                  ctl,
    input  logic signed [POS_W-1:0]   position,
    output logic signed [SPEED_W-1:0] speed
);

    logic signed [POS_W-1:0]   pos_reg;
    logic signed [POS_W-1:0]   held_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic [POS_W-1:0]          mag_s2_reg;
    logic                      neg_s2_reg;
    logic [POS_W-1:0]          mag_s3_reg;
    logic                      neg_s3_reg;
    logic [QUOT_W-1:0]         quot_s3_reg;

    logic signed [POS_W:0]     diff;
    logic [POS_W:0]            mag_wide;
    logic [POS_W+QUOT_W-1:0]   recip_prod;
    logic [POS_W:0]            back_prod;
    logic [POS_W:0]            remainder;
    logic [QUOT_W-1:0]         quot;
    logic signed [SPEED_W-1:0] speed_next;

    // The magnitude of the difference never exceeds 2^32 - 1.
    assign diff     = {pos_reg[POS_W-1], pos_reg} - {held_reg[POS_W-1], held_reg};
    assign mag_wide = diff[POS_W] ? -diff : diff;

    // The estimate is the true quotient or one below it.
    assign recip_prod = {{QUOT_W{1'b0}}, mag_s2_reg} * {{POS_W{1'b0}}, DIV_RECIP};
    assign back_prod  = (POS_W+1)'(quot_s3_reg) * (POS_W+1)'(SPEED_DIV);
    assign remainder  = {1'b0, mag_s3_reg} - back_prod;

    always_comb
    begin
        quot = quot_s3_reg;
        if (remainder >= (POS_W+1)'(SPEED_DIV))
        begin
            quot = quot_s3_reg + QUOT_W'(1);
        end
        speed_next = neg_s3_reg ? -SPEED_W'(quot) : SPEED_W'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            pos_reg     <= position;
            mag_s2_reg  <= mag_wide[POS_W-1:0];
            neg_s2_reg  <= diff[POS_W];
            mag_s3_reg  <= mag_s2_reg;
            neg_s3_reg  <= neg_s2_reg;
            quot_s3_reg <= recip_prod[POS_W+QUOT_W-1:POS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            speed_reg <= '0;
        end
        else
        begin
            if (ctl.hold)
            begin
                held_reg <= pos_reg;
            end
            if (ctl.update)
            begin
                speed_reg <= speed_next;
            end
        end
    end

    assign speed = speed_reg;

endmodule

// ===== design/dmpr_pi_wheel.sv =====
// Incremental PI step of one wheel with symmetric saturation.
// Depends on dmpr_pkg; instantiated twice by the top level.
module dmpr_pi_wheel
    import dmpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic signed [DRIVE_W-1:0] target,
    input  logic signed [SPEED_W-1:0] speed,
    input  logic [GAIN_W-1:0]         prop_gain,
    input  logic [GAIN_W-1:0]         integ_gain,
    input  logic [CFG_W-1:0]          limit,
    output logic signed [DRIVE_W-1:0] drive_next
);

    localparam int DIFF_W = SPEED_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int INC_W  = ACC_W - 8;
    localparam int SUM_W  = INC_W + 1;

    logic signed [SPEED_W-1:0] prev_error_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic signed [SPEED_W-1:0] err;
    logic signed [DIFF_W-1:0]  err_diff;
    logic signed [DIFF_W-1:0]  err_sum;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [ACC_W-1:0]   acc;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;

    always_comb
    begin
        err      = {{(SPEED_W-DRIVE_W){target[DRIVE_W-1]}}, target} - speed;
        err_diff = {err[SPEED_W-1], err} - {prev_error_reg[SPEED_W-1], prev_error_reg};
        err_sum  = {err[SPEED_W-1], err} + {prev_error_reg[SPEED_W-1], prev_error_reg};
        prod_p   = PROD_W'($signed({1'b0, prop_gain})) * PROD_W'(err_diff);
        prod_i   = PROD_W'($signed({1'b0, integ_gain})) * PROD_W'(err_sum);
        acc      = {prod_p[PROD_W-1], prod_p} + {prod_i[PROD_W-1], prod_i};
        // Dropping the low eight bits of a two's complement value rounds down.
        sum      = {{(SUM_W-DRIVE_W){drive_reg[DRIVE_W-1]}}, drive_reg}
                 + {acc[ACC_W-1], acc[ACC_W-1:8]};
        lim_pos  = {{(SUM_W-CFG_W){1'b0}}, limit};
        lim_neg  = -lim_pos;
        if (sum > lim_pos)
        begin
            drive_next = lim_pos[DRIVE_W-1:0];
        end
        else if (sum < lim_neg)
        begin
            drive_next = lim_neg[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            drive_reg      <= '0;
        end
        else if (step)
        begin
            prev_error_reg <= err;
            drive_reg      <= drive_next;
        end
    end

endmodule

// ===== design/dual_motor_pi_speed_regulator.sv =====
// Top level of the dual motor PI speed regulator: configuration, pipeline control,
// motion decode and PWM output stage. Depends on dmpr_pkg, dmpr_speed_est, dmpr_pi_wheel.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    command, motion, motor_select,
//                                   position_left, position_right
//   output   out_valid / out_ready  pwm_value
//   config   cfg_write              cfg_index, cfg_data (no handshake back)
//
// The block is a five stage pipeline taking one transaction per cycle unless stalled.
// A regulate transaction shows its PWM value in the output register after the last stage;
// a sample transaction gives no result and leaves a bubble in the pipeline.
// Reset clears the configuration to its defaults and all wheel state to zero.
// The pipeline stalls only when a result sits in the output register untaken
// and another result waits in the last stage behind it.
module dual_motor_pi_speed_regulator
    import dmpr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [2:0]              motion,
    input  logic [1:0]              motor_select,
    input  logic signed [POS_W-1:0] position_left,
    input  logic signed [POS_W-1:0] position_right,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PWM_W-1:0]        pwm_value,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    // Configuration registers.
    logic [CFG_W-1:0]  target_speed_reg;
    logic [CFG_W-1:0]  output_limit_reg;
    logic [GAIN_W-1:0] prop_gain_left_reg;
    logic [GAIN_W-1:0] integ_gain_left_reg;
    logic [GAIN_W-1:0] prop_gain_right_reg;
    logic [GAIN_W-1:0] integ_gain_right_reg;

    // Pipeline control. Stage one holds the accepted transaction, stage two and
    // three run the speed division, stage four the PI step, stage five the PWM.
    stage_t s1_reg;
    stage_t s2_reg;
    stage_t s3_reg;
    stage_t s4_reg;
    logic   s5_valid_reg;
    logic   s5_sel_ok_reg;
    logic signed [SDRIVE_W-1:0] s5_sdrive_reg;
    logic   second_sample_reg;

    logic                   out_valid_reg;
    logic [PWM_W-1:0]       pwm_reg;

    logic                      advance;
    logic                      is_sample;
    spd_ctl_t                  spd_ctl;
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [DRIVE_W-1:0] target_pos;
    logic signed [DRIVE_W-1:0] target_left;
    logic signed [DRIVE_W-1:0] target_right;
    logic signed [DRIVE_W-1:0] drive_next_left;
    logic signed [DRIVE_W-1:0] drive_next_right;
    logic                      pi_step;
    logic signed [SDRIVE_W-1:0] s5_sdrive_next;
    logic                      s5_sel_ok_next;
    logic signed [PWM_SUM_W-1:0] sdrive_ext;
    logic signed [PWM_SUM_W-1:0] pwm_sum;
    stage_t                    s1_next;
    stage_t                    s2_next;

    // Everything moves together unless a finished result would be overwritten.
    assign advance   = !(out_valid_reg && !out_ready && s5_valid_reg);
    assign in_ready  = advance;
    assign is_sample = s1_reg.valid && !s1_reg.regulate;

    always_comb
    begin
        s1_next.valid    = in_valid;
        s1_next.regulate = command;
        s1_next.divide   = 1'b0;
        s1_next.motion   = motion;
        s1_next.motor    = motor_select;

        s2_next          = s1_reg;
        s2_next.divide   = is_sample && second_sample_reg;
    end

    // The first sample of a pair stores the positions, the second one divides.
    assign spd_ctl.advance = advance;
    assign spd_ctl.hold    = advance && is_sample && !second_sample_reg;
    assign spd_ctl.update  = advance && s3_reg.valid && s3_reg.divide;

    dmpr_speed_est u_speed_left
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (spd_ctl),
        .position (position_left),
        .speed    (speed_left)
    );

    dmpr_speed_est u_speed_right
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (spd_ctl),
        .position (position_right),
        .speed    (speed_right)
    );

    // Motion decode into signed per-wheel targets.
    assign target_pos = $signed({1'b0, target_speed_reg});

    always_comb
    begin
        case (s4_reg.motion)
            MOTION_STOP:
            begin
                target_left  = '0;
                target_right = '0;
            end
            MOTION_FORWARD:
            begin
                target_left  = target_pos;
                target_right = target_pos;
            end
            MOTION_BACKWARD:
            begin
                target_left  = -target_pos;
                target_right = -target_pos;
            end
            MOTION_CW:
            begin
                target_left  = target_pos;
                target_right = -target_pos;
            end
            MOTION_CCW:
            begin
                target_left  = -target_pos;
                target_right = target_pos;
            end
            default:
            begin
                target_left  = '0;
                target_right = '0;
            end
        endcase
    end

    // Both wheels step on every regulate transaction.
    assign pi_step = advance && s4_reg.valid && s4_reg.regulate;

    dmpr_pi_wheel u_pi_left
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (pi_step),
        .target     (target_left),
        .speed      (speed_left),
        .prop_gain  (prop_gain_left_reg),
        .integ_gain (integ_gain_left_reg),
        .limit      (output_limit_reg),
        .drive_next (drive_next_left)
    );

    dmpr_pi_wheel u_pi_right
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (pi_step),
        .target     (target_right),
        .speed      (speed_right),
        .prop_gain  (prop_gain_right_reg),
        .integ_gain (integ_gain_right_reg),
        .limit      (output_limit_reg),
        .drive_next (drive_next_right)
    );

    // The right motor is mounted mirrored, so its drive enters with inverted sign.
    always_comb
    begin
        case (s4_reg.motor)
            MOTOR_LEFT:
            begin
                s5_sdrive_next = SDRIVE_W'(drive_next_left);
                s5_sel_ok_next = 1'b1;
            end
            MOTOR_RIGHT:
            begin
                s5_sdrive_next = -SDRIVE_W'(drive_next_right);
                s5_sel_ok_next = 1'b1;
            end
            default:
            begin
                s5_sdrive_next = '0;
                s5_sel_ok_next = 1'b0;
            end
        endcase
    end

    // PWM = center + 25 * drive in Q16.16; the sum is always positive, so the
    // integer part is a plain bit slice.
    assign sdrive_ext = PWM_SUM_W'(s5_sdrive_reg);
    assign pwm_sum    = $signed(PWM_CENTER_Q16) + (sdrive_ext <<< 4) + (sdrive_ext <<< 3)
                      + sdrive_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg     <= RST_TARGET_SPEED;
            output_limit_reg     <= RST_OUTPUT_LIMIT;
            prop_gain_left_reg   <= RST_PROP_GAIN_LEFT;
            integ_gain_left_reg  <= RST_INTEG_GAIN_LEFT;
            prop_gain_right_reg  <= RST_PROP_GAIN_RIGHT;
            integ_gain_right_reg <= RST_INTEG_GAIN_RIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TARGET_SPEED:     target_speed_reg     <= cfg_data;
                CFG_OUTPUT_LIMIT:     output_limit_reg     <= cfg_data;
                CFG_PROP_GAIN_LEFT:   prop_gain_left_reg   <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN_LEFT:  integ_gain_left_reg  <= cfg_data[GAIN_W-1:0];
                CFG_PROP_GAIN_RIGHT:  prop_gain_right_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN_RIGHT: integ_gain_right_reg <= cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg            <= '0;
            s2_reg            <= '0;
            s3_reg            <= '0;
            s4_reg            <= '0;
            s5_valid_reg      <= 1'b0;
            second_sample_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s2_reg;
            s4_reg       <= s3_reg;
            s5_valid_reg <= s4_reg.valid && s4_reg.regulate;
            if (is_sample)
            begin
                second_sample_reg <= !second_sample_reg;
            end
            if (s5_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_sdrive_reg <= s5_sdrive_next;
            s5_sel_ok_reg <= s5_sel_ok_next;
            if (s5_valid_reg)
            begin
                pwm_reg <= s5_sel_ok_reg ? pwm_sum[PWM_W+15:16] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pwm_value = pwm_reg;

endmodule

// ===== test/dmpr_pwm_checker_pkg.sv =====
// PWM checker for the dual motor PI speed regulator testbench: a cycle-free
// predictor of both wheel regulators plus the queue of PWM values still due.
// Depends on dmpr_pkg for widths, register indexes, reset values and codes.
package dmpr_pwm_checker_pkg;
    import dmpr_pkg::*;

    localparam longint PWM_MID_Q16     = longint'(7500) * 65536;
    localparam longint PWM_STEP        = 25;
    localparam longint TICKS_PER_SPEED = 100;

    class pwm_checker;
        logic [CFG_W-1:0]    target_speed;
        logic [CFG_W-1:0]    output_limit;
        logic [GAIN_W-1:0]   kp_left;
        logic [GAIN_W-1:0]   ki_left;
        logic [GAIN_W-1:0]   kp_right;
        logic [GAIN_W-1:0]   ki_right;
        bit                  second_sample;
        int                  held_left;
        int                  held_right;
        int                  speed_left;
        int                  speed_right;
        int                  err_left;
        int                  err_right;
        int                  drive_left;
        int                  drive_right;
        logic [PWM_W-1:0]    pwm_due[$];
        int                  failures;

        function new();
            target_speed  = RST_TARGET_SPEED;
            output_limit  = RST_OUTPUT_LIMIT;
            kp_left       = RST_PROP_GAIN_LEFT;
            ki_left       = RST_INTEG_GAIN_LEFT;
            kp_right      = RST_PROP_GAIN_RIGHT;
            ki_right      = RST_INTEG_GAIN_RIGHT;
            second_sample = 1'b0;
            held_left     = 0;
            held_right    = 0;
            speed_left    = 0;
            speed_right   = 0;
            err_left      = 0;
            err_right     = 0;
            drive_left    = 0;
            drive_right   = 0;
            failures      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_TARGET_SPEED:     target_speed = data;
                CFG_OUTPUT_LIMIT:     output_limit = data;
                CFG_PROP_GAIN_LEFT:   kp_left      = data[GAIN_W-1:0];
                CFG_INTEG_GAIN_LEFT:  ki_left      = data[GAIN_W-1:0];
                CFG_PROP_GAIN_RIGHT:  kp_right     = data[GAIN_W-1:0];
                CFG_INTEG_GAIN_RIGHT: ki_right     = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // One incremental PI step; the increment is floored, then the drive
        // is clamped to the symmetric output limit.
        function int pi_update(int drive, int err, int prev,
                               logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki);
            longint lim;
            longint acc;
            longint next;
            lim  = longint'(output_limit);
            acc  = longint'(kp) * (longint'(err) - longint'(prev))
                 + longint'(ki) * (longint'(err) + longint'(prev));
            next = longint'(drive) + (acc >>> 8);
            if (next > lim)
                next = lim;
            if (next < -lim)
                next = -lim;
            return int'(next);
        endfunction

        function void accept_item(bit cmd, logic [2:0] mot, logic [1:0] sel,
                                  int pos_left, int pos_right);
            longint v;
            longint tgt_left;
            longint tgt_right;
            longint level;
            int     e_left;
            int     e_right;
            if (!cmd)
            begin
                if (!second_sample)
                begin
                    held_left  = pos_left;
                    held_right = pos_right;
                end
                else
                begin
                    // Signed division truncates toward zero, as the block does.
                    speed_left  = int'((longint'(pos_left) - longint'(held_left))
                                       / TICKS_PER_SPEED);
                    speed_right = int'((longint'(pos_right) - longint'(held_right))
                                       / TICKS_PER_SPEED);
                end
                second_sample = !second_sample;
                return;
            end
            v         = longint'(target_speed);
            tgt_left  = 0;
            tgt_right = 0;
            case (mot)
                MOTION_FORWARD:
                begin
                    tgt_left  = v;
                    tgt_right = v;
                end
                MOTION_BACKWARD:
                begin
                    tgt_left  = -v;
                    tgt_right = -v;
                end
                MOTION_CW:
                begin
                    tgt_left  = v;
                    tgt_right = -v;
                end
                MOTION_CCW:
                begin
                    tgt_left  = -v;
                    tgt_right = v;
                end
                default: ;
            endcase
            e_left      = int'(tgt_left - longint'(speed_left));
            e_right     = int'(tgt_right - longint'(speed_right));
            drive_left  = pi_update(drive_left, e_left, err_left, kp_left, ki_left);
            drive_right = pi_update(drive_right, e_right, err_right, kp_right, ki_right);
            err_left    = e_left;
            err_right   = e_right;
            if (sel == MOTOR_LEFT)
                level = PWM_MID_Q16 + PWM_STEP * longint'(drive_left);
            else if (sel == MOTOR_RIGHT)
                level = PWM_MID_Q16 - PWM_STEP * longint'(drive_right);
            else
                level = 0;
            if (level < 0)
                level = 0;
            pwm_due.push_back(PWM_W'(level / 65536));
        endfunction

        function void check_pwm(logic [PWM_W-1:0] got);
            logic [PWM_W-1:0] want;
            if (pwm_due.size() == 0)
            begin
                failures++;
                $display("%0t: pwm_value %0d arrived with no transaction pending",
                         $time, got);
                return;
            end
            want = pwm_due.pop_front();
            if (got !== want)
            begin
                failures++;
                $display("%0t: pwm_value expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

endpackage

// ===== test/testbench.sv =====
// Testbench top for the dual motor PI speed regulator: drives directed and random
// transactions with random gaps and stalls and checks every PWM value.
// Depends on dmpr_pkg, dmpr_pwm_checker_pkg and the block itself.
module testbench;
    import dmpr_pkg::*;
    import dmpr_pwm_checker_pkg::*;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int MAX_WAIT        = 16;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SRC             = 0;
    localparam int SNK             = 1;

    // Transaction kinds.
    localparam bit CMD_SAMPLE   = 1'b0;
    localparam bit CMD_REGULATE = 1'b1;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    command;
    logic [2:0]              motion;
    logic [1:0]              motor_select;
    logic signed [POS_W-1:0] position_left;
    logic signed [POS_W-1:0] position_right;
    logic                    out_valid;
    logic                    out_ready;
    logic [PWM_W-1:0]        pwm_value;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    pwm_checker sb;
    int         pwm_taken   = 0;
    int         cycle_count = 0;
    int         quiet_left[2];
    int         last_left   = 0;
    int         last_right  = 0;

    dual_motor_pi_speed_regulator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .motion         (motion),
        .motor_select   (motor_select),
        .position_left  (position_left),
        .position_right (position_right),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pwm_value      (pwm_value),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a run that passes this limit ends as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Number of idle cycles before the next transaction on one side. Most
    // draws are short or zero; now and then a side runs flat out for a while
    // so that back-to-back traffic is exercised as well.
    function automatic int draw_wait(int side);
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet_left[side] = $urandom_range(10, 40);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Monitor. Everything is sampled at the rising edge; the stimulus only
    // moves on falling edges, so the values seen here are stable. The output
    // is checked before the input is noted, although the pipeline latency
    // would keep the two apart anyway.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_pwm(pwm_value);
                pwm_taken++;
            end
            if (in_valid && in_ready)
                sb.accept_item(command, motion, motor_select,
                               position_left, position_right);
        end
    end

    // Offer one transaction after a random gap and hold it until accepted.
    // Valid is lowered only when a gap is drawn, so a back-to-back item keeps
    // valid high across the edge with just the payload changing.
    task automatic send(bit cmd, logic [2:0] mot, logic [1:0] sel, int pl, int pr);
        int gap;
        gap = draw_wait(SRC);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       = 1'b1;
        command        = cmd;
        motion         = mot;
        motor_select   = sel;
        position_left  = pl;
        position_right = pr;
        do @(posedge clk); while (!in_ready);
    endtask

    // A position sample. Motion and motor selection are meaningless here, so
    // they carry noise to show that the block ignores them.
    task automatic sample(int pl, int pr);
        last_left  = pl;
        last_right = pr;
        send(CMD_SAMPLE, 3'($urandom), 2'($urandom), pl, pr);
    endtask

    // Random traffic: mostly regulate requests with the defined motions and
    // a valid motor, some unknown motions and invalid selections, and sample
    // pairs that usually move a plausible distance so that speeds stay in a
    // range where the regulator does not simply sit on its limit.
    task automatic random_item();
        logic [2:0] mot;
        logic [1:0] sel;
        int         pl;
        int         pr;
        if ($urandom_range(0, 9) < 6)
        begin
            if ($urandom_range(0, 3) == 0)
                mot = 3'($urandom_range(0, 7));
            else
                mot = 3'($urandom_range(MOTION_FORWARD, MOTION_CCW));
            if ($urandom_range(0, 4) == 0)
                sel = 2'($urandom_range(0, 3));
            else
                sel = $urandom_range(0, 1) ? MOTOR_LEFT : MOTOR_RIGHT;
            send(CMD_REGULATE, mot, sel, int'($urandom), int'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pl = int'($urandom);
                pr = int'($urandom);
            end
            else
            begin
                pl = last_left + int'($urandom_range(0, 8388608)) - 4194304;
                pr = last_right + int'($urandom_range(0, 8388608)) - 4194304;
            end
            sample(pl, pr);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        sb.write_register(idx, val);
    endtask

    // Rewrite the whole register set; only called while the block is idle.
    task automatic configure(logic [CFG_W-1:0] speed, logic [CFG_W-1:0] limit,
                             logic [GAIN_W-1:0] kpl, logic [GAIN_W-1:0] kil,
                             logic [GAIN_W-1:0] kpr, logic [GAIN_W-1:0] kir);
        write_register(CFG_TARGET_SPEED, speed);
        write_register(CFG_OUTPUT_LIMIT, limit);
        write_register(CFG_PROP_GAIN_LEFT, CFG_W'(kpl));
        write_register(CFG_INTEG_GAIN_LEFT, CFG_W'(kil));
        write_register(CFG_PROP_GAIN_RIGHT, CFG_W'(kpr));
        write_register(CFG_INTEG_GAIN_RIGHT, CFG_W'(kir));
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Wait until every PWM value is in, then give a trailing sample
    // transaction (which has no result) time to leave the pipeline.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pwm_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Directed opening: field extremes, every motion and motor code, and the
    // corner cases of the speed estimate.
    task automatic directed();
        // Regulate straight out of reset with both speeds at zero.
        send(CMD_REGULATE, MOTION_STOP, MOTOR_LEFT, 0, 0);
        // Largest possible position swing, positive on the left wheel and
        // negative on the right one.
        sample(int'(32'h8000_0000), int'(32'h7fff_ffff));
        sample(int'(32'h7fff_ffff), int'(32'h8000_0000));
        // Every motion code including the unknown ones, paired with every
        // motor selection including the invalid ones. Positions are noise.
        for (int m = 0; m < 8; m++)
            send(CMD_REGULATE, 3'(m), 2'(m % 4), int'($urandom), int'($urandom));
        // A small negative difference must truncate toward zero, not floor.
        sample(0, 0);
        sample(-199, 199);
        send(CMD_REGULATE, MOTION_FORWARD, MOTOR_LEFT, -1, -1);
        send(CMD_REGULATE, MOTION_BACKWARD, MOTOR_RIGHT, int'(32'h8000_0000), -1);
        send(CMD_REGULATE, MOTION_CW, MOTOR_LEFT, int'(32'h7fff_ffff), 0);
        send(CMD_REGULATE, MOTION_CCW, MOTOR_RIGHT, 0, int'(32'h7fff_ffff));
    endtask

    // Result side. Each result waits a random number of cycles before ready
    // goes high. Twice in the run the receiver holds off for a long stretch
    // while the sender keeps offering, so the pipeline fills and in_ready
    // drops.
    initial
    begin
        int stall;
        int next_hold;
        out_ready = 1'b0;
        next_hold = 40;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(SNK);
            if (pwm_taken >= next_hold)
            begin
                stall     = LONG_HOLD;
                next_hold = next_hold + 300;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Main sequence: reset, directed opening, then one random phase per
    // register setting. Phase 0 runs on the reset values; the others cover
    // the upper extremes, all zeros (output pinned at the center), fully
    // random registers and a moderate setting with a random limit.
    initial
    begin
        sb             = new();
        quiet_left[SRC] = 0;
        quiet_left[SNK] = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_SAMPLE;
        motion         = MOTION_STOP;
        motor_select   = '0;
        position_left  = '0;
        position_right = '0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_TARGET_SPEED;
        cfg_data       = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1: configure(24'd8388608, 24'd8388608,
                             16'hffff, 16'hffff, 16'hffff, 16'hffff);
                2: configure('0, '0, '0, '0, '0, '0);
                3: configure(CFG_W'($urandom_range(0, 8388608)),
                             CFG_W'($urandom_range(0, 8388608)),
                             GAIN_W'($urandom), GAIN_W'($urandom),
                             GAIN_W'($urandom), GAIN_W'($urandom));
                4: configure(CFG_W'($urandom_range(0, 131072)),
                             CFG_W'($urandom_range(65536, 7864320)),
                             GAIN_W'($urandom_range(0, 2048)),
                             GAIN_W'($urandom_range(0, 512)),
                             GAIN_W'($urandom_range(0, 2048)),
                             GAIN_W'($urandom_range(0, 512)));
                default: ;
            endcase
            repeat (ITEMS_PER_PHASE) random_item();
            settle();
        end

        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
